// ===== rtl/vra_pkg.sv =====
`default_nettype none
package vra_pkg;

	localparam int CORDIC_STEPS = 24;
	localparam int VW = 32;
	localparam int AW = 36;

	localparam logic signed [AW-1:0] ONE_Q30     = 36'sd1073741824;
	localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
	localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [AW-1:0] GAIN_Q30    = 36'sd652032874;

	typedef enum logic [1:0] {
		MODE_X    = 2'd0,
		MODE_Y    = 2'd1,
		MODE_Z    = 2'd2,
		MODE_AXIS = 2'd3
	} mode_t;

	// cos/sin result from the cordic lane
	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} cs_t;

	function automatic logic signed [AW-1:0] atan_q30(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 36'sd843314857;
			1: r = 36'sd497837829;
			2: r = 36'sd263043837;
			3: r = 36'sd133525159;
			4: r = 36'sd67021687;
			5: r = 36'sd33543516;
			6: r = 36'sd16775851;
			7: r = 36'sd8388437;
			8: r = 36'sd4194283;
			9: r = 36'sd2097149;
			default: r = (i < 31) ? (36'sd1 <<< (30 - i)) : 36'sd0;
		endcase
		return r;
	endfunction

	// round half up by sh bits
	function automatic logic signed [79:0] rnd_sh(input logic signed [79:0] v, input int sh);
		return (v + (80'sd1 <<< (sh - 1))) >>> sh;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vector_rotate_axis_angle_core.sv =====
`default_nettype none
// Rotates the xyz part of a Q16.16 vector by a Q4.28 angle about X, Y, Z or a
// Q2.30 axis (Rodrigues); w passes through. Fully pipelined: busy stays low,
// an item may be started every cycle, and its result appears with done high
// for one cycle once it has passed 24 cordic stages plus range reduce,
// 4 matrix-build stages and 2 row stages. The receiver cannot stall; sample
// out_* whenever done is high. Three row lanes run side by side after a shared
// cos/sin cordic.
module vector_rotate_axis_angle_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] angle,
	input  wire logic [31:0] vec_x,
	input  wire logic [31:0] vec_y,
	input  wire logic [31:0] vec_z,
	input  wire logic [31:0] vec_w,
	input  wire logic [31:0] axis_x,
	input  wire logic [31:0] axis_y,
	input  wire logic [31:0] axis_z,
	output logic             done,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic [31:0]      out_z,
	output logic [31:0]      out_w
);
	localparam int CD = vra_pkg::CORDIC_STEPS + 1;
	localparam int LAT = CD + 4 + 2;
	localparam int DW = 2 + 7 * 32;

	vra_pkg::cs_t cs;
	logic [LAT-1:0] vld_q;
	logic [DW-1:0] dly_q [0:CD-1];
	logic [1:0] md;
	logic signed [31:0] vx, vy, vz, vw, ax, ay, az;
	logic signed [35:0] m [0:8];
	logic signed [31:0] vx_s1, vy_s1, vz_s1, vw_s1, c_s1, s_s1, ax_s1, ay_s1, az_s1;
	logic [1:0] md_s1;
	logic signed [63:0] pxx_s2, pxy_s2, pxz_s2, pyy_s2, pyz_s2, pzz_s2;
	logic signed [63:0] sx_s2, sy_s2, sz_s2;
	logic signed [32:0] u_s2;
	logic signed [31:0] c_s2, s_s2;
	logic signed [31:0] vx_s2, vy_s2, vz_s2, vw_s2;
	logic [1:0] md_s2;
	logic signed [32:0] qxx_s3, qxy_s3, qxz_s3, qyy_s3, qyz_s3, qzz_s3;
	logic signed [33:0] tx_s3, ty_s3, tz_s3;
	logic signed [32:0] u_s3;
	logic signed [31:0] c_s3, s_s3, vx_s3, vy_s3, vz_s3, vw_s3;
	logic [1:0] md_s3;
	logic signed [65:0] uxx_s4, uxy_s4, uxz_s4, uyy_s4, uyz_s4, uzz_s4;
	logic signed [33:0] tx_s4, ty_s4, tz_s4;
	logic signed [31:0] c_s4, s_s4, vx_s4, vy_s4, vz_s4, vw_s4, vw_s5, vw_s6;
	logic [1:0] md_s4;
	logic signed [35:0] c4, s4, bxx, bxy, bxz, byy, byz, bzz;

	assign busy = 1'b0;

	vra_cordic u_cordic (.clk(clk), .angle(angle), .cs(cs));

	// operand delay matching the cordic
	always_ff @(posedge clk) begin
		dly_q[0] <= {mode, vec_x, vec_y, vec_z, vec_w, axis_x, axis_y, axis_z};
		for (int i = 1; i < CD; i++) dly_q[i] <= dly_q[i-1];
	end
	assign {md, vx, vy, vz, vw, ax, ay, az} = dly_q[CD-1];

	// matrix build stage 1: register cos/sin and operands
	always_ff @(posedge clk) begin
		c_s1 <= cs.c; s_s1 <= cs.s; md_s1 <= md;
		vx_s1 <= vx; vy_s1 <= vy; vz_s1 <= vz; vw_s1 <= vw;
		ax_s1 <= ax; ay_s1 <= ay; az_s1 <= az;
	end

	// stage 2: pair products and sin products
	always_ff @(posedge clk) begin
		pxx_s2 <= ax_s1 * ax_s1; pxy_s2 <= ax_s1 * ay_s1; pxz_s2 <= ax_s1 * az_s1;
		pyy_s2 <= ay_s1 * ay_s1; pyz_s2 <= ay_s1 * az_s1; pzz_s2 <= az_s1 * az_s1;
		sx_s2 <= s_s1 * ax_s1; sy_s2 <= s_s1 * ay_s1; sz_s2 <= s_s1 * az_s1;
		// u reaches 2.0 at cos = -1, so it needs a 33-bit signed word
		u_s2 <= 33'(vra_pkg::ONE_Q30) - 33'(c_s1);
		c_s2 <= c_s1; s_s2 <= s_s1; md_s2 <= md_s1;
		vx_s2 <= vx_s1; vy_s2 <= vy_s1; vz_s2 <= vz_s1; vw_s2 <= vw_s1;
	end

	// stage 3: round pairs to q29, sin terms to q30
	always_ff @(posedge clk) begin
		qxx_s3 <= 33'(vra_pkg::rnd_sh(80'(pxx_s2), 31));
		qxy_s3 <= 33'(vra_pkg::rnd_sh(80'(pxy_s2), 31));
		qxz_s3 <= 33'(vra_pkg::rnd_sh(80'(pxz_s2), 31));
		qyy_s3 <= 33'(vra_pkg::rnd_sh(80'(pyy_s2), 31));
		qyz_s3 <= 33'(vra_pkg::rnd_sh(80'(pyz_s2), 31));
		qzz_s3 <= 33'(vra_pkg::rnd_sh(80'(pzz_s2), 31));
		tx_s3 <= 34'(vra_pkg::rnd_sh(80'(sx_s2), 30));
		ty_s3 <= 34'(vra_pkg::rnd_sh(80'(sy_s2), 30));
		tz_s3 <= 34'(vra_pkg::rnd_sh(80'(sz_s2), 30));
		u_s3 <= u_s2; c_s3 <= c_s2; s_s3 <= s_s2; md_s3 <= md_s2;
		vx_s3 <= vx_s2; vy_s3 <= vy_s2; vz_s3 <= vz_s2; vw_s3 <= vw_s2;
	end

	// stage 4: u times pair
	always_ff @(posedge clk) begin
		uxx_s4 <= u_s3 * qxx_s3; uxy_s4 <= u_s3 * qxy_s3; uxz_s4 <= u_s3 * qxz_s3;
		uyy_s4 <= u_s3 * qyy_s3; uyz_s4 <= u_s3 * qyz_s3; uzz_s4 <= u_s3 * qzz_s3;
		tx_s4 <= tx_s3; ty_s4 <= ty_s3; tz_s4 <= tz_s3;
		c_s4 <= c_s3; s_s4 <= s_s3; md_s4 <= md_s3;
		vx_s4 <= vx_s3; vy_s4 <= vy_s3; vz_s4 <= vz_s3; vw_s4 <= vw_s3;
	end

	// coefficient select per mode; rows clip to [-2, 2] on entry
	always_comb begin
		c4 = 36'(c_s4);
		s4 = 36'(s_s4);
		bxx = 36'(vra_pkg::rnd_sh(80'(uxx_s4), 29));
		bxy = 36'(vra_pkg::rnd_sh(80'(uxy_s4), 29));
		bxz = 36'(vra_pkg::rnd_sh(80'(uxz_s4), 29));
		byy = 36'(vra_pkg::rnd_sh(80'(uyy_s4), 29));
		byz = 36'(vra_pkg::rnd_sh(80'(uyz_s4), 29));
		bzz = 36'(vra_pkg::rnd_sh(80'(uzz_s4), 29));
		for (int k = 0; k < 9; k++) m[k] = '0;
		case (vra_pkg::mode_t'(md_s4))
			vra_pkg::MODE_X: begin
				m[0] = vra_pkg::ONE_Q30; m[4] = c4; m[5] = -s4; m[7] = s4; m[8] = c4;
			end
			vra_pkg::MODE_Y: begin
				m[0] = c4; m[2] = s4; m[4] = vra_pkg::ONE_Q30; m[6] = -s4; m[8] = c4;
			end
			vra_pkg::MODE_Z: begin
				m[0] = c4; m[1] = -s4; m[3] = s4; m[4] = c4; m[8] = vra_pkg::ONE_Q30;
			end
			default: begin
				m[0] = c4 + bxx;    m[1] = bxy - tz_s4; m[2] = bxz + ty_s4;
				m[3] = bxy + tz_s4; m[4] = c4 + byy;    m[5] = byz - tx_s4;
				m[6] = bxz - ty_s4; m[7] = byz + tx_s4; m[8] = c4 + bzz;
			end
		endcase
	end

	// three row lanes
	vra_row u_row_x (.clk(clk), .m0(m[0]), .m1(m[1]), .m2(m[2]),
		.v0(vx_s4), .v1(vy_s4), .v2(vz_s4), .res(out_x));
	vra_row u_row_y (.clk(clk), .m0(m[3]), .m1(m[4]), .m2(m[5]),
		.v0(vx_s4), .v1(vy_s4), .v2(vz_s4), .res(out_y));
	vra_row u_row_z (.clk(clk), .m0(m[6]), .m1(m[7]), .m2(m[8]),
		.v0(vx_s4), .v1(vy_s4), .v2(vz_s4), .res(out_z));

	always_ff @(posedge clk) begin
		vw_s5 <= vw_s4;
		vw_s6 <= vw_s5;
	end
	assign out_w = vw_s6;

	// item valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end
	assign done = vld_q[LAT-1];

`ifndef SYNTH
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[LAT-2] |=> done) else $error("done lost");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[LAT-2] |=> !done) else $error("spurious done");
	a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule
`default_nettype wire

// ===== rtl/vra_cordic.sv =====
`default_nettype none
module vra_cordic (
	input  wire logic               clk,
	input  wire logic signed [31:0] angle,
	output vra_pkg::cs_t            cs
);
	localparam int N = vra_pkg::CORDIC_STEPS;
	localparam int W = vra_pkg::AW;

	logic signed [W-1:0] x_q [0:N];
	logic signed [W-1:0] y_q [0:N];
	logic signed [W-1:0] a_q [0:N];
	logic                neg_q [0:N];
	logic signed [W-1:0] a0, a1;
	logic                neg0;
	logic signed [W-1:0] xf, yf;

	// range reduction into [-pi/2, pi/2]
	always_comb begin
		a0 = {{(W-32){angle[31]}}, angle} <<< 2;
		if (a0 > vra_pkg::PI_Q30) a0 = a0 - vra_pkg::TWO_PI_Q30;
		else if (a0 < -vra_pkg::PI_Q30) a0 = a0 + vra_pkg::TWO_PI_Q30;
		neg0 = 1'b0;
		a1 = a0;
		if (a0 > vra_pkg::HALF_PI_Q30) begin
			a1 = a0 - vra_pkg::PI_Q30;
			neg0 = 1'b1;
		end else if (a0 < -vra_pkg::HALF_PI_Q30) begin
			a1 = a0 + vra_pkg::PI_Q30;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		x_q[0] <= vra_pkg::GAIN_Q30;
		y_q[0] <= '0;
		a_q[0] <= a1;
		neg_q[0] <= neg0;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (a_q[i] >= 0) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				a_q[i+1] <= a_q[i] - vra_pkg::atan_q30(i);
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				a_q[i+1] <= a_q[i] + vra_pkg::atan_q30(i);
			end
			neg_q[i+1] <= neg_q[i];
		end
	end

	always_comb begin
		xf = neg_q[N] ? -x_q[N] : x_q[N];
		yf = neg_q[N] ? -y_q[N] : y_q[N];
		if (xf > vra_pkg::ONE_Q30) xf = vra_pkg::ONE_Q30;
		else if (xf < -vra_pkg::ONE_Q30) xf = -vra_pkg::ONE_Q30;
		if (yf > vra_pkg::ONE_Q30) yf = vra_pkg::ONE_Q30;
		else if (yf < -vra_pkg::ONE_Q30) yf = -vra_pkg::ONE_Q30;
		cs.c = xf[31:0];
		cs.s = yf[31:0];
	end
endmodule
`default_nettype wire

// ===== rtl/vra_row.sv =====
`default_nettype none
module vra_row (
	input  wire logic               clk,
	input  wire logic signed [35:0] m0,
	input  wire logic signed [35:0] m1,
	input  wire logic signed [35:0] m2,
	input  wire logic signed [31:0] v0,
	input  wire logic signed [31:0] v1,
	input  wire logic signed [31:0] v2,
	output logic signed [31:0]      res
);
	logic signed [65:0] p0_s1, p1_s1, p2_s1;
	logic signed [67:0] sum_s2;
	logic signed [79:0] r;
	logic signed [33:0] c0, c1, c2;

	function automatic logic signed [33:0] clip(input logic signed [35:0] m);
		if (m > 36'sd2147483648) return 34'sd2147483648;
		if (m < -36'sd2147483648) return -34'sd2147483648;
		return 34'(m);
	endfunction

	assign c0 = clip(m0);
	assign c1 = clip(m1);
	assign c2 = clip(m2);

	always_ff @(posedge clk) begin
		p0_s1 <= c0 * v0;
		p1_s1 <= c1 * v1;
		p2_s1 <= c2 * v2;
		sum_s2 <= 68'(p0_s1 >>> 2) + 68'(p1_s1 >>> 2) + 68'(p2_s1 >>> 2);
	end

	always_comb begin
		r = vra_pkg::rnd_sh(80'(sum_s2), 28);
		if (r > 80'sd2147483647) res = 32'h7fffffff;
		else if (r < -80'sd2147483648) res = 32'h80000000;
		else res = r[31:0];
	end
endmodule
`default_nettype wire

// ===== tb/sv/vector_rotate_axis_angle_checker.sv =====
`timescale 1ns / 100ps
`default_nettype none
module vector_rotate_axis_angle_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  mode,
	input  wire logic [31:0] angle,
	input  wire logic [31:0] vec_x,
	input  wire logic [31:0] vec_y,
	input  wire logic [31:0] vec_z,
	input  wire logic [31:0] vec_w,
	input  wire logic [31:0] axis_x,
	input  wire logic [31:0] axis_y,
	input  wire logic [31:0] axis_z,
	input  wire logic        done,
	input  wire logic [31:0] out_x,
	input  wire logic [31:0] out_y,
	input  wire logic [31:0] out_z,
	input  wire logic [31:0] out_w,
	output int               errors,
	output int               pending,
	output int               seen
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic [31:0] w;
	} rot_vec_t;

	localparam longint ATAN_TAB [0:23] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
	localparam longint ONE = 64'sd1073741824;
	localparam longint PI = 64'sd3373259426;
	localparam longint TWO_PI = 64'sd6746518852;
	localparam longint HALF_PI = 64'sd1686629713;
	localparam longint GAIN = 64'sd652032874;
	localparam longint CLIM = 64'sd2147483648;

	rot_vec_t rotated_q[$];

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint rshift_rnd(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic logic [31:0] row_sum(longint m0, longint m1, longint m2,
			longint v0, longint v1, longint v2);
		longint acc;
		acc = ((clip(m0, -CLIM, CLIM) * v0) >>> 2) + ((clip(m1, -CLIM, CLIM) * v1) >>> 2)
			+ ((clip(m2, -CLIM, CLIM) * v2) >>> 2);
		return 32'(clip(rshift_rnd(acc, 28), -64'sd2147483648, 64'sd2147483647));
	endfunction

	function automatic longint upair(longint u, longint a, longint b);
		return rshift_rnd(u * rshift_rnd(a * b, 31), 29);
	endfunction

	function automatic rot_vec_t rotate(logic [1:0] md, logic [31:0] ang,
			logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w,
			logic [31:0] ux, logic [31:0] uy, logic [31:0] uz);
		longint a, cx, cy, t, c, s, u, ax, ay, az, v0, v1, v2;
		longint m [0:8];
		bit flip;
		rot_vec_t r;
		a = longint'(signed'(ang)) * 4;
		flip = 0;
		if (a > PI) a -= TWO_PI;
		else if (a < -PI) a += TWO_PI;
		if (a > HALF_PI) begin a -= PI; flip = 1; end
		else if (a < -HALF_PI) begin a += PI; flip = 1; end
		// rotation-mode cordic from the gain-compensated start point
		cx = GAIN;
		cy = 0;
		for (int i = 0; i < vra_pkg::CORDIC_STEPS; i++) begin
			if (a >= 0) begin
				t = cx - (cy >>> i); cy = cy + (cx >>> i); a -= ATAN_TAB[i];
			end else begin
				t = cx + (cy >>> i); cy = cy - (cx >>> i); a += ATAN_TAB[i];
			end
			cx = t;
		end
		if (flip) begin cx = -cx; cy = -cy; end
		c = clip(cx, -ONE, ONE);
		s = clip(cy, -ONE, ONE);
		ax = longint'(signed'(ux));
		ay = longint'(signed'(uy));
		az = longint'(signed'(uz));
		v0 = longint'(signed'(x));
		v1 = longint'(signed'(y));
		v2 = longint'(signed'(z));
		case (vra_pkg::mode_t'(md))
			vra_pkg::MODE_X: m = '{ONE, 0, 0, 0, c, -s, 0, s, c};
			vra_pkg::MODE_Y: m = '{c, 0, s, 0, ONE, 0, -s, 0, c};
			vra_pkg::MODE_Z: m = '{c, -s, 0, s, c, 0, 0, 0, ONE};
			default: begin
				u = ONE - c;
				m[0] = c + upair(u, ax, ax);
				m[1] = upair(u, ax, ay) - rshift_rnd(s * az, 30);
				m[2] = upair(u, ax, az) + rshift_rnd(s * ay, 30);
				m[3] = upair(u, ax, ay) + rshift_rnd(s * az, 30);
				m[4] = c + upair(u, ay, ay);
				m[5] = upair(u, ay, az) - rshift_rnd(s * ax, 30);
				m[6] = upair(u, ax, az) - rshift_rnd(s * ay, 30);
				m[7] = upair(u, ay, az) + rshift_rnd(s * ax, 30);
				m[8] = c + upair(u, az, az);
			end
		endcase
		r.x = row_sum(m[0], m[1], m[2], v0, v1, v2);
		r.y = row_sum(m[3], m[4], m[5], v0, v1, v2);
		r.z = row_sum(m[6], m[7], m[8], v0, v1, v2);
		r.w = w;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s at %0t: got %h want %h", what, $time, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rot_vec_t exp_v;
		if (!arst_n) begin
			errors = 0;
			seen = 0;
			pending = 0;
		end else begin
			if (start && !busy)
				rotated_q.push_back(rotate(mode, angle, vec_x, vec_y, vec_z, vec_w,
					axis_x, axis_y, axis_z));
			if (done) begin
				seen++;
				if (rotated_q.size() == 0) begin
					$display("unexpected result at %0t", $time);
					errors++;
				end else begin
					exp_v = rotated_q.pop_front();
					if (out_x !== exp_v.x) report("out_x", out_x, exp_v.x);
					if (out_y !== exp_v.y) report("out_y", out_y, exp_v.y);
					if (out_z !== exp_v.z) report("out_z", out_z, exp_v.z);
					if (out_w !== exp_v.w) report("out_w", out_w, exp_v.w);
				end
			end
			pending = rotated_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/vector_rotate_axis_angle_core_test.sv =====
`timescale 1ns / 100ps
`default_nettype none
module vector_rotate_axis_angle_core_test;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1900;
	// Q2.30 one and common axis values
	localparam logic [31:0] AXIS_ONE = 32'h4000_0000;
	localparam logic [31:0] AXIS_INV_SQRT3 = 32'd619925131;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [1:0]  mode = vra_pkg::MODE_X;
	logic [31:0] angle = 0, vec_x = 0, vec_y = 0, vec_z = 0, vec_w = 0;
	logic [31:0] axis_x = 0, axis_y = 0, axis_z = 0;
	wire logic        busy, done;
	wire logic [31:0] out_x, out_y, out_z, out_w;
	int errors, pending, seen;
	int idle_cycles;
	int issued;

	always #5 clk = ~clk;

	vector_rotate_axis_angle_core dut (.*);

	vector_rotate_axis_angle_checker checker_i (.*);

	// watchdog: count cycles in which neither an item nor a result moves
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (arst_n && idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	// component values biased toward the extremes and small magnitudes
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 255)) - 32'd128;
			3, 4: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	// unit axis half of the time, bounded or arbitrary axis otherwise
	task automatic pick_axis(output logic [31:0] ux, output logic [31:0] uy,
			output logic [31:0] uz);
		case ($urandom_range(0, 5))
			0: begin ux = AXIS_ONE; uy = 0; uz = 0; end
			1: begin ux = 0; uy = -AXIS_ONE; uz = 0; end
			2: begin ux = AXIS_INV_SQRT3; uy = -AXIS_INV_SQRT3; uz = AXIS_INV_SQRT3; end
			3: begin ux = pick_word(); uy = pick_word(); uz = pick_word(); end
			default: begin
				ux = 32'($urandom_range(0, 32'h7000_0000)) - 32'h3800_0000;
				uy = 32'($urandom_range(0, 32'h7000_0000)) - 32'h3800_0000;
				uz = 32'($urandom_range(0, 32'h7000_0000)) - 32'h3800_0000;
			end
		endcase
	endtask

	// hold an item on the inputs until the block takes it, then idle for a random gap, which may be zero
	task automatic send(logic [1:0] md, logic [31:0] ang, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] w, logic [31:0] ux,
			logic [31:0] uy, logic [31:0] uz);
		int gap;
		start <= 1;
		mode <= md;
		angle <= ang;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		vec_w <= w;
		axis_x <= ux;
		axis_y <= uy;
		axis_z <= uz;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
		// no gap in long stretches, mostly short gaps, a few long ones
		gap = ($urandom_range(0, 3) == 0) ? 0 :
			($urandom_range(0, 15) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 3));
		if ((issued / 100) % 3 == 1) gap = 0;
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [31:0] ux, uy, uz;
		issued = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every mode at zero, quarter turn, pi, angle extremes
		for (int md = 0; md < 4; md++) begin
			send(2'(md), 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h1234_5678,
				AXIS_INV_SQRT3, AXIS_INV_SQRT3, AXIS_INV_SQRT3);
			send(2'(md), 32'd421657428, 32'h0001_0000, 0, 32'hffff_0000, 32'h8000_0000,
				0, 0, AXIS_ONE);
			send(2'(md), 32'd843314856, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
				32'h7fff_ffff, AXIS_ONE, 0, 0);
			send(2'(md), 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
				32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
			send(2'(md), 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 1, 32'hffff_ffff,
				32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		end
		// non-unit axis with a saturating rotation
		send(vra_pkg::MODE_AXIS, 32'hc000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 5, 32'h8000_0000, 32'h7fff_ffff, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick_axis(ux, uy, uz);
			send(2'($urandom_range(0, 3)), ($urandom_range(0, 4) == 0) ? pick_word() :
				32'($urandom_range(0, 32'h6487_ed51 * 2)) - 32'h6487_ed51,
				pick_word(), pick_word(), pick_word(), $urandom, ux, uy, uz);
		end
		start <= 0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items sent, %0d results checked, all four modes", issued, seen);
		$display("angles over the full Q4.28 range, unit and non-unit axes, saturation");
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
